@@ rtl/ff4_pkg.sv @@
package ff4_pkg;

    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int FUNC_W    = 2;
    localparam int COORD_W   = 6;
    localparam int VALUE_W   = 16;
    localparam int DATA_W    = 16;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    // Wide enough for the largest limit, whether it comes from a register or MAX_ROWS.
    localparam int LIM_W     = 11;

    localparam int RESET_ROWS = 64;
    localparam int RESET_COLS = 64;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FILL  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_SEED,
        ST_POP,
        ST_POP_WAIT,
        ST_NB_RD,
        ST_NB_CHK
    } ff4_state_t;

    typedef enum logic [1:0] {
        NB_UP,
        NB_LEFT,
        NB_DOWN,
        NB_RIGHT
    } nb_dir_t;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_ERR,
        OUT_ZERO,
        OUT_READ,
        OUT_COUNT
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     wr_in;
        logic     rd_in;
        logic     start;
        logic     pop;
        logic     ld_cur;
        logic     nb_rd;
        logic     nb_chk;
        logic     nb_next;
        out_sel_t out_sel;
    } ff4_cmd_t;

    typedef struct packed {
        logic in_ok;
        logic seed_same;
        logic stack_empty;
        logic nb_inside;
        logic nb_last;
        logic out_free;
    } ff4_stat_t;

endpackage

@@ rtl/ff4_ctrl.sv @@
module ff4_ctrl import ff4_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [FUNC_W-1:0] s_func,
    output logic              s_ready,
    input  ff4_stat_t         stat,
    output ff4_cmd_t          cmd
);

    ff4_state_t state_reg;
    ff4_state_t state_next;
    logic       take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.out_sel = OUT_NONE;
        s_ready     = 1'b0;
        take        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // Words that produce a result wait for a free output register.
                if (s_func == FUNC_FILL || s_func == FUNC_READ) begin
                    s_ready = stat.out_free;
                end else begin
                    s_ready = 1'b1;
                end
                take = s_valid && s_ready;
                if (take) begin
                    cmd.accept = 1'b1;
                    case (s_func)
                        FUNC_WRITE: begin
                            cmd.wr_in = 1'b1;
                        end
                        FUNC_READ: begin
                            if (stat.in_ok) begin
                                cmd.rd_in  = 1'b1;
                                state_next = ST_RD;
                            end else begin
                                cmd.out_sel = OUT_ERR;
                            end
                        end
                        FUNC_FILL: begin
                            if (stat.in_ok) begin
                                cmd.rd_in  = 1'b1;
                                state_next = ST_SEED;
                            end else begin
                                cmd.out_sel = OUT_ERR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD: begin
                cmd.out_sel = OUT_READ;
                state_next  = ST_IDLE;
            end
            ST_SEED: begin
                if (stat.seed_same) begin
                    cmd.out_sel = OUT_ZERO;
                    state_next  = ST_IDLE;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                if (stat.stack_empty) begin
                    cmd.out_sel = OUT_COUNT;
                    state_next  = ST_IDLE;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT: begin
                cmd.ld_cur = 1'b1;
                state_next = ST_NB_RD;
            end
            ST_NB_RD: begin
                if (stat.nb_inside) begin
                    cmd.nb_rd  = 1'b1;
                    state_next = ST_NB_CHK;
                end else if (stat.nb_last) begin
                    state_next = ST_POP;
                end else begin
                    cmd.nb_next = 1'b1;
                end
            end
            ST_NB_CHK: begin
                cmd.nb_chk = 1'b1;
                if (stat.nb_last) begin
                    state_next = ST_POP;
                end else begin
                    cmd.nb_next = 1'b1;
                    state_next  = ST_NB_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ff4_dp.sv @@
module ff4_dp import ff4_pkg::*; #(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic [COORD_W-1:0]   s_row,
    input  logic [COORD_W-1:0]   s_col,
    input  logic [VALUE_W-1:0]   s_value,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [DATA_W-1:0]    m_data,
    output logic                 m_status,
    input  ff4_cmd_t             cmd,
    output ff4_stat_t            stat
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = ROW_W + COL_W;
    localparam int DEPTH = 1 << AW;
    localparam int CNT_W = AW + 1;

    // Pixel addresses, and the addresses held on the stack, are {row, col}.
    logic [PIXEL_BITS-1:0] img_mem [DEPTH];
    logic [AW-1:0]         stk_mem [DEPTH];

    logic [CFG_W-1:0]      rows_reg;
    logic [CFG_W-1:0]      cols_reg;
    logic [LIM_W-1:0]      rows_ext;
    logic [LIM_W-1:0]      cols_ext;
    logic [LIM_W-1:0]      lim_rows;
    logic [LIM_W-1:0]      lim_cols;

    logic                  in_ok;
    logic [AW-1:0]         in_addr;
    logic [PIXEL_BITS-1:0] value_px;

    logic [AW-1:0]         seed_addr_reg;
    logic [PIXEL_BITS-1:0] colour_reg;
    logic [PIXEL_BITS-1:0] seed_colour_reg;
    logic [AW-1:0]         cur_addr_reg;
    nb_dir_t               nb_reg;
    nb_dir_t               nb_next;
    logic [CNT_W-1:0]      depth_reg;
    logic [CNT_W-1:0]      depth_next;
    logic [CNT_W-1:0]      depth_m1;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [PIXEL_BITS-1:0] img_rdata_reg;
    logic [AW-1:0]         stk_rdata_reg;

    logic [ROW_W-1:0]      cur_row;
    logic [COL_W-1:0]      cur_col;
    logic [ROW_W-1:0]      nb_row;
    logic [COL_W-1:0]      nb_col;
    logic                  nb_inside;
    logic [AW-1:0]         nb_addr;
    logic                  nb_match;
    logic                  push_nb;

    logic                  img_we;
    logic [AW-1:0]         img_wa;
    logic [PIXEL_BITS-1:0] img_wd;
    logic                  img_re;
    logic [AW-1:0]         img_ra;
    logic                  stk_we;
    logic [AW-1:0]         stk_wd;

    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [DATA_W-1:0]     m_data_reg;
    logic [DATA_W-1:0]     m_data_next;
    logic                  m_status_reg;
    logic                  m_status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= CFG_W'(RESET_ROWS);
            cols_reg <= CFG_W'(RESET_COLS);
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_ROWS) begin
                rows_reg <= cfg_wr_data;
            end
            if (cfg_index == REG_COLS) begin
                cols_reg <= cfg_wr_data;
            end
        end
    end

    assign rows_ext = LIM_W'(rows_reg);
    assign cols_ext = LIM_W'(cols_reg);
    assign lim_rows = (rows_ext < LIM_W'(MAX_ROWS)) ? rows_ext : LIM_W'(MAX_ROWS);
    assign lim_cols = (cols_ext < LIM_W'(MAX_COLS)) ? cols_ext : LIM_W'(MAX_COLS);

    assign in_ok    = (LIM_W'(s_row) < lim_rows) && (LIM_W'(s_col) < lim_cols);
    assign in_addr  = {ROW_W'(s_row), COL_W'(s_col)};
    assign value_px = PIXEL_BITS'(s_value);

    assign cur_row = cur_addr_reg[AW-1:COL_W];
    assign cur_col = cur_addr_reg[COL_W-1:0];

    always_comb begin
        nb_row    = cur_row;
        nb_col    = cur_col;
        nb_inside = 1'b0;
        nb_next   = nb_reg;
        case (nb_reg)
            NB_UP: begin
                nb_row    = cur_row - ROW_W'(1);
                nb_inside = (cur_row != '0);
                nb_next   = NB_LEFT;
            end
            NB_LEFT: begin
                nb_col    = cur_col - COL_W'(1);
                nb_inside = (cur_col != '0);
                nb_next   = NB_DOWN;
            end
            NB_DOWN: begin
                nb_row    = cur_row + ROW_W'(1);
                nb_inside = (LIM_W'(cur_row) + LIM_W'(1)) < lim_rows;
                nb_next   = NB_RIGHT;
            end
            NB_RIGHT: begin
                nb_col    = cur_col + COL_W'(1);
                nb_inside = (LIM_W'(cur_col) + LIM_W'(1)) < lim_cols;
                nb_next   = NB_UP;
            end
            default: ;
        endcase
    end

    assign nb_addr  = {nb_row, nb_col};
    assign nb_match = (img_rdata_reg == seed_colour_reg);
    // A pixel is recolored as it is pushed, so it can never match the seed
    // colour again; that stands in for a visited map.
    assign push_nb  = cmd.nb_chk && nb_match;

    assign img_we = (cmd.wr_in && in_ok) || cmd.start || push_nb;
    assign img_wa = cmd.wr_in ? in_addr : (cmd.start ? seed_addr_reg : nb_addr);
    assign img_wd = cmd.wr_in ? value_px : colour_reg;
    assign img_re = cmd.rd_in || cmd.nb_rd;
    assign img_ra = cmd.rd_in ? in_addr : nb_addr;

    always_ff @(posedge aclk) begin
        if (img_we) begin
            img_mem[img_wa] <= img_wd;
        end
        if (img_re) begin
            img_rdata_reg <= img_mem[img_ra];
        end
    end

    assign stk_we   = cmd.start || push_nb;
    assign stk_wd   = cmd.start ? seed_addr_reg : nb_addr;
    assign depth_m1 = depth_reg - CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[depth_reg[AW-1:0]] <= stk_wd;
        end
        if (cmd.pop) begin
            stk_rdata_reg <= stk_mem[depth_m1[AW-1:0]];
        end
    end

    always_comb begin
        depth_next = depth_reg;
        count_next = count_reg;
        if (cmd.start) begin
            depth_next = CNT_W'(1);
            count_next = CNT_W'(1);
        end else if (push_nb) begin
            depth_next = depth_reg + CNT_W'(1);
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            depth_next = depth_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            count_reg <= '0;
            nb_reg    <= NB_UP;
        end else begin
            depth_reg <= depth_next;
            count_reg <= count_next;
            if (cmd.ld_cur) begin
                nb_reg <= NB_UP;
            end else if (cmd.nb_next) begin
                nb_reg <= nb_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            seed_addr_reg <= in_addr;
            colour_reg    <= value_px;
        end
        if (cmd.start) begin
            seed_colour_reg <= img_rdata_reg;
        end
        if (cmd.ld_cur) begin
            cur_addr_reg <= stk_rdata_reg;
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        case (cmd.out_sel)
            OUT_ERR: begin
                m_valid_next  = 1'b1;
                m_data_next   = '0;
                m_status_next = 1'b1;
            end
            OUT_ZERO: begin
                m_valid_next  = 1'b1;
                m_data_next   = '0;
                m_status_next = 1'b0;
            end
            OUT_READ: begin
                m_valid_next  = 1'b1;
                m_data_next   = DATA_W'(img_rdata_reg);
                m_status_next = 1'b0;
            end
            OUT_COUNT: begin
                m_valid_next  = 1'b1;
                m_status_next = 1'b0;
                if (32'(count_reg) > 32'hFFFF) begin
                    m_data_next = '1;
                end else begin
                    m_data_next = DATA_W'(count_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;

    assign stat.in_ok       = in_ok;
    assign stat.seed_same   = (img_rdata_reg == colour_reg);
    assign stat.stack_empty = (depth_reg == '0);
    assign stat.nb_inside   = nb_inside;
    assign stat.nb_last     = (nb_reg == NB_RIGHT);
    assign stat.out_free    = !m_valid_reg || m_ready;

endmodule

@@ rtl/flood_fill_4_connected.sv @@
// Image store with 4-connected flood fill. A pixel write word is taken every cycle while
// idle and produces no result. A pixel read is accepted with a registered image memory
// read, then loads the output register, and is taken only when the output register is
// free or being emptied. A fill reads and compares the seed, then for each recolored
// pixel pops the stack, then reads and compare-writes the image memory for each in-range
// neighbor, and finally loads the count; input stalls throughout. The result for a fill
// is the number of recolored pixels, saturated at 65535; a seed, read or write outside
// the rows and columns in use gives status 1 (no result for a write). Configuration
// writes apply at once and must be made while idle.
module flood_fill_4_connected import ff4_pkg::*; #(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FUNC_W-1:0]    s_func,
    input  logic [COORD_W-1:0]   s_row,
    input  logic [COORD_W-1:0]   s_col,
    input  logic [VALUE_W-1:0]   s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_W-1:0]    m_data,
    output logic                 m_status
);

    ff4_cmd_t  cmd;
    ff4_stat_t stat;

    ff4_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ff4_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_value     (s_value),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .m_status    (m_status),
        .cmd         (cmd),
        .stat        (stat)
    );

    // A result word is only ever loaded into a free output register.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_sel != OUT_NONE) |-> stat.out_free)
        else $error("result loaded over a waiting word");

    // An in-range fill blocks input on the following cycle.
    a_fill_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func == FUNC_FILL && stat.in_ok) |=> !s_ready)
        else $error("input taken during a fill");

    // The stack is never popped when empty.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !stat.stack_empty)
        else $error("stack popped while empty");

endmodule
